// ===== rtl/core/sbot_pkg.sv =====
`timescale 1ns / 1ps

package sbot_pkg;

  // Default sizes
  localparam int MAX_BOXES_DEF  = 256;
  localparam int COORD_BITS_DEF = 16;

  // Rotation format, Q1.14
  localparam int ROT_BITS    = 16;
  localparam int ROUND_SHIFT = 14;

  // Fixed widths of the port fields
  localparam int INDEX_BITS = 8;
  localparam int COUNT_BITS = 9;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  localparam logic REG_BOX_COUNT  = 1'b0;
  localparam logic REG_DOORS_OPEN = 1'b1;

  // Control travelling with each box through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic skip;
  } box_tag_t;

endpackage

// ===== rtl/core/sbot_ram.sv =====
`timescale 1ns / 1ps

module sbot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sbot_xform.sv =====
`timescale 1ns / 1ps

module sbot_xform
  import sbot_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  localparam int OW = CW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  box_tag_t             tag_in,
  input  logic signed [CW-1:0] a [3],
  input  logic signed [CW-1:0] b [3],
  input  logic signed [CW-1:0] ctr [3],
  input  logic signed [CW-1:0] half_in [3],
  input  logic signed [ROT_BITS-1:0] cos_in,
  input  logic signed [ROT_BITS-1:0] sin_in,
  output box_tag_t             tag_out,
  output logic signed [OW-1:0] o [3],
  output logic signed [OW-1:0] q [3],
  output logic signed [CW-1:0] half_out [3]
);

  localparam int DAW = CW + 1;
  localparam int PW  = DAW + ROT_BITS;
  localparam int SW  = PW + 2;

  box_tag_t tag1, tag2;
  logic signed [DAW-1:0] da [3];
  logic signed [DAW-1:0] db [3];
  logic signed [CW-1:0]  h1 [3];
  logic signed [CW-1:0]  h2 [3];
  logic signed [ROT_BITS-1:0] c1, s1;
  logic signed [PW-1:0] ca0, sa2, sa0, ca2, cb0, sb2, sb0, cb2;
  logic signed [DAW-1:0] ay2, by2;

  // Stage 1: offsets from the centre
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag_in;
    end
    for (int k = 0; k < 3; k++) begin
      da[k] <= DAW'(a[k]) - DAW'(ctr[k]);
      db[k] <= DAW'(b[k]) - DAW'(ctr[k]);
      h1[k] <= half_in[k];
    end
    c1 <= cos_in;
    s1 <= sin_in;
  end

  // Stage 2: rotation products
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else begin
      tag2 <= tag1;
    end
    ca0 <= PW'(c1) * PW'(da[0]);
    sa2 <= PW'(s1) * PW'(da[2]);
    sa0 <= PW'(s1) * PW'(da[0]);
    ca2 <= PW'(c1) * PW'(da[2]);
    cb0 <= PW'(c1) * PW'(db[0]);
    sb2 <= PW'(s1) * PW'(db[2]);
    sb0 <= PW'(s1) * PW'(db[0]);
    cb2 <= PW'(c1) * PW'(db[2]);
    ay2 <= da[1];
    by2 <= db[1];
    h2  <= h1;
  end

  // Stage 3: sum, round to nearest (ties up) back to Q8.8
  logic signed [SW-1:0] rxa, rza, rxb, rzb;
  localparam logic signed [SW-1:0] BIAS = SW'(1) <<< (ROUND_SHIFT - 1);

  always_comb begin
    rxa = SW'(ca0) - SW'(sa2) + BIAS;
    rza = SW'(sa0) + SW'(ca2) + BIAS;
    rxb = SW'(cb0) - SW'(sb2) + BIAS;
    rzb = SW'(sb0) + SW'(cb2) + BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag2;
    end
    o[0] <= OW'(rxa >>> ROUND_SHIFT);
    o[1] <= OW'(ay2);
    o[2] <= OW'(rza >>> ROUND_SHIFT);
    q[0] <= OW'(rxb >>> ROUND_SHIFT);
    q[1] <= OW'(by2);
    q[2] <= OW'(rzb >>> ROUND_SHIFT);
    half_out <= h2;
  end

endmodule

// ===== rtl/core/sbot_slab.sv =====
`timescale 1ns / 1ps

module sbot_slab
  import sbot_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  localparam int OW = CW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  box_tag_t             tag_in,
  input  logic signed [OW-1:0] o [3],
  input  logic signed [OW-1:0] q [3],
  input  logic signed [CW-1:0] half [3],
  output box_tag_t             tag_out,
  output logic                 hit
);

  localparam int DW = CW + 6;
  localparam int MW = 2 * DW;

  // Stage 4: per-axis slab limits, direction made positive
  box_tag_t tag4, tag5;
  logic signed [DW-1:0] lo [3];
  logic signed [DW-1:0] hi [3];
  logic signed [DW-1:0] dd [3];
  logic [2:0] zero4, zrej4;

  logic signed [DW-1:0] d_c [3];
  logic signed [DW-1:0] l_c [3];
  logic signed [DW-1:0] u_c [3];
  logic signed [DW-1:0] oe [3];
  logic signed [DW-1:0] he [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oe[k]  = DW'(o[k]);
      he[k]  = DW'(half[k]);
      d_c[k] = DW'(q[k]) - oe[k];
      l_c[k] = -he[k] - oe[k];
      u_c[k] = he[k] - oe[k];
      if (d_c[k] < 0) begin
        d_c[k] = -d_c[k];
        l_c[k] = -l_c[k];
        u_c[k] = -u_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4 <= '0;
    end else begin
      tag4 <= tag_in;
    end
    for (int k = 0; k < 3; k++) begin
      dd[k]    <= d_c[k];
      lo[k]    <= (l_c[k] > u_c[k]) ? u_c[k] : l_c[k];
      hi[k]    <= (l_c[k] > u_c[k]) ? l_c[k] : u_c[k];
      zero4[k] <= (d_c[k] == '0);
      zrej4[k] <= (d_c[k] == '0) && ((oe[k] < -he[k]) || (oe[k] > he[k]));
    end
  end

  // Stage 5: cross products of every entry/exit pair
  logic signed [MW-1:0] pl [3][3];
  logic signed [MW-1:0] ph [3][3];
  logic [2:0] zero5, axok5;
  logic       zrej5;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5 <= '0;
    end else begin
      tag5 <= tag4;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pl[i][j] <= MW'(lo[i]) * MW'(dd[j]);
        ph[i][j] <= MW'(hi[j]) * MW'(dd[i]);
      end
      axok5[i] <= (lo[i] <= dd[i]) && (hi[i] >= 0);
    end
    zero5 <= zero4;
    zrej5 <= |zrej4;
  end

  // Stage 6: latest entry must not pass earliest exit
  logic ok;

  always_comb begin
    ok = !zrej5;
    for (int i = 0; i < 3; i++) begin
      if (!zero5[i] && !axok5[i]) begin
        ok = 1'b0;
      end
      for (int j = 0; j < 3; j++) begin
        if (!zero5[i] && !zero5[j] && (pl[i][j] > ph[i][j])) begin
          ok = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag5;
    end
    hit <= ok && !tag5.skip;
  end

endmodule

// ===== rtl/core/segment_box_occlusion_test_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | command, box_index, p0_*, p1_*, cos_yaw,
//         |           |                       | sin_yaw, door_flag
// result  | out       | out_valid / out_stall | path_clear
// config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A query walks the box table through a seven-deep pipeline (table read, offset, rotate,
// round, limits, cross products, compare) at one box per cycle, a rate set by the single
// table read port. It walks box_count boxes (count saturated to the table size), and goes
// straight to its answer when that count is zero. An answer waits on a held stalled word.
// Synchronous active-high reset clears control and the registers; table contents are
// undefined until loaded. in_stall is high from a query until its word is handed to the
// output register, which holds it against out_stall.

module segment_box_occlusion_test_core
  import sbot_pkg::*;
#(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [INDEX_BITS-1:0]       box_index,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [ROT_BITS-1:0]  cos_yaw,
  input  logic signed [ROT_BITS-1:0]  sin_yaw,
  input  logic                        door_flag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        path_clear,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [COUNT_BITS-1:0]       cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int NW   = $clog2(MAX_BOXES + 1);
  localparam int CMPW = (NW > COUNT_BITS) ? NW : COUNT_BITS;
  localparam int RW   = 6 * CW + 2 * ROT_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [COUNT_BITS-1:0] box_count;
  logic doors_open;
  logic [NW-1:0] idx, n_boxes;
  logic acc_clear, result;
  logic signed [CW-1:0] qa [3];
  logic signed [CW-1:0] qb [3];

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count  <= '0;
      doors_open <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_COUNT:  box_count  <= cfg_data;
        REG_DOORS_OPEN: doors_open <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Active box count, saturated to the table size
  logic [CMPW-1:0] cnt_ext;
  assign cnt_ext = CMPW'(box_count);
  assign n_boxes = (cnt_ext > CMPW'(MAX_BOXES)) ? NW'(MAX_BOXES) : NW'(cnt_ext);

  logic accept, is_load, is_query;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_load  = accept && (command == CMD_LOAD)
                    && (CMPW'(box_index) < CMPW'(MAX_BOXES));
  assign is_query = accept && (command == CMD_QUERY);

  // Box table
  logic [RW-1:0] wdata, rdata;
  logic [AW-1:0] raddr;
  assign wdata = {door_flag, sin_yaw, cos_yaw, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};
  assign raddr = idx[AW-1:0];

  sbot_ram #(.WIDTH(RW), .DEPTH(MAX_BOXES)) u_table (
    .clk   (clk),
    .we    (is_load),
    .waddr (AW'(box_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Issue tag, aligned with the registered read
  box_tag_t tag_rd, tag_x, tag_s;
  logic issue;
  assign issue = (state == ST_ISSUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
    end else begin
      tag_rd.valid <= issue;
      tag_rd.last  <= issue && (idx == n_boxes - NW'(1));
      tag_rd.skip  <= 1'b0;
    end
  end

  box_tag_t tag_in_x;
  logic signed [CW-1:0] ctr [3];
  logic signed [CW-1:0] hsz [3];
  logic signed [CW-1:0] hsz_x [3];
  logic signed [CW+3:0] o [3];
  logic signed [CW+3:0] q [3];
  logic hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k] = rdata[k*CW +: CW];
      hsz[k] = rdata[(k+3)*CW +: CW];
    end
    tag_in_x      = tag_rd;
    tag_in_x.skip = rdata[RW-1] && doors_open;
  end

  sbot_xform #(.CW(CW)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag_in_x),
    .a        (qa),
    .b        (qb),
    .ctr      (ctr),
    .half_in  (hsz),
    .cos_in   (rdata[6*CW +: ROT_BITS]),
    .sin_in   (rdata[6*CW+ROT_BITS +: ROT_BITS]),
    .tag_out  (tag_x),
    .o        (o),
    .q        (q),
    .half_out (hsz_x)
  );

  sbot_slab #(.CW(CW)) u_slab (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_x),
    .o       (o),
    .q       (q),
    .half    (hsz_x),
    .tag_out (tag_s),
    .hit     (hit)
  );

  // Query endpoints held for the walk
  always_ff @(posedge clk) begin
    if (is_query) begin
      qa[0] <= p0_x; qa[1] <= p0_y; qa[2] <= p0_z;
      qb[0] <= p1_x; qb[1] <= p1_y; qb[2] <= p1_z;
    end
  end

  // Sequencer and result accumulation
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      acc_clear  <= 1'b1;
      result     <= 1'b1;
      out_valid  <= 1'b0;
      path_clear <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (is_query) begin
            idx       <= '0;
            acc_clear <= 1'b1;
            if (n_boxes == '0) begin
              result <= 1'b1;
              state  <= ST_DONE;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          idx <= idx + NW'(1);
          if (idx == n_boxes - NW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tag_s.valid && tag_s.last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            path_clear <= result;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (tag_s.valid) begin
        acc_clear <= acc_clear && !hit;
        if (tag_s.last) begin
          result <= acc_clear && !hit;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sbot_checker.sv =====
`timescale 1ns / 1ps

module sbot_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic command,
  input logic out_valid,
  input logic out_stall,
  input logic path_clear,
  input logic cfg_ready
);

  // Held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(path_clear))
    else $error("result word changed while stalled");

  // An accepted query closes the input
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command |=> in_stall)
    else $error("input open right after a query");

  // Nothing delivered straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

  // Register port always takes writes
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind segment_box_occlusion_test_core sbot_checker u_sbot_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .command    (command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .path_clear (path_clear),
  .cfg_ready  (cfg_ready)
);
